>>> rtl/core/laec_pkg.sv
// ----------------------------------------------------------------------------
// laec_pkg
// Shared types and constants of the LMS echo canceller core.
// ----------------------------------------------------------------------------
package laec_pkg;

	// Reset value of the adaptation gain (Q31)
	localparam logic signed [31:0] STEP_RESET = 32'sd814748000;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILT,
		ST_FDRAIN,
		ST_ERR,
		ST_GMUL,
		ST_GLOAD,
		ST_UPD,
		ST_UDRAIN,
		ST_DONE
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic clear_step;
		logic load;
		logic issue;
		logic upd;
		logic err_calc;
		logic gain_mul;
		logic gain_load;
		logic out_load;
		logic in_ready;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic last_tap;
		logic pipe_empty;
		logic out_free;
	} status_t;

endpackage

>>> rtl/core/laec_ram.sv
// ----------------------------------------------------------------------------
// laec_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module laec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/laec_ctrl.sv
// ----------------------------------------------------------------------------
// laec_ctrl
// Sequencer: clearing pass, filter sweep, gain, coefficient update, output.
// ----------------------------------------------------------------------------
module laec_ctrl
	import laec_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (status.clear_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_FILT;
			ST_FILT:   if (status.last_tap) state_d = ST_FDRAIN;
			ST_FDRAIN: if (status.pipe_empty) state_d = ST_ERR;
			ST_ERR:    state_d = ST_GMUL;
			ST_GMUL:   state_d = ST_GLOAD;
			ST_GLOAD:  state_d = ST_UPD;
			ST_UPD:    if (status.last_tap) state_d = ST_UDRAIN;
			ST_UDRAIN: if (status.pipe_empty) state_d = ST_DONE;
			ST_DONE:   if (status.out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clear_step = 1'b1;
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = in_valid;
			end
			ST_FILT:   cmd.issue = 1'b1;
			ST_ERR:    cmd.err_calc = 1'b1;
			ST_GMUL:   cmd.gain_mul = 1'b1;
			ST_GLOAD:  cmd.gain_load = 1'b1;
			ST_UPD: begin
				cmd.issue = 1'b1;
				cmd.upd   = 1'b1;
			end
			ST_DONE:   cmd.out_load = status.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

>>> rtl/core/laec_dp.sv
// ----------------------------------------------------------------------------
// laec_dp
// Datapath: delay line and coefficient RAMs, shared Q31 multiplier, output.
// ----------------------------------------------------------------------------
module laec_dp
	import laec_pkg::*;
#(
	parameter int TAPS       = 51,
	parameter int LINE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic               step_size_we,
	input  logic signed [31:0] step_size,
	input  logic signed [15:0] clean_sample,
	input  logic signed [15:0] echo_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] error_sample
);

	localparam int LAW  = $clog2(LINE_DEPTH);
	localparam int TAW  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int MAXD = (LINE_DEPTH > TAPS) ? LINE_DEPTH : TAPS;
	localparam int SW   = $clog2(MAXD);

	// control registers
	logic [SW-1:0]  sweep_q;
	logic [LAW-1:0] wp_q;
	logic [LAW-1:0] rd_idx_q;
	logic [TAW-1:0] tap_q;
	logic           v_s1, v_s2;
	logic           upd_s1, upd_s2;
	logic           out_valid_q;
	logic signed [31:0] step_q;

	// payload registers
	logic [LAW-1:0]     newest_q;
	logic signed [15:0] echo_q;
	logic [TAW-1:0]     tap_s1, tap_s2;
	logic [31:0]        coef_s2;
	logic signed [63:0] prod_s2;
	logic [31:0]        est_q;
	logic [31:0]        err_q;
	logic [31:0]        g_q;
	logic signed [15:0] out_data_q;

	// RAM ports
	logic           line_we;
	logic [LAW-1:0] line_waddr;
	logic [15:0]    line_wdata;
	logic [15:0]    line_rdata;
	logic           coef_we;
	logic [TAW-1:0] coef_waddr;
	logic [31:0]    coef_wdata;
	logic [31:0]    coef_rdata;

	logic signed [31:0] mul_a, mul_b;
	logic [31:0]        q31;
	logic [LAW-1:0]     rd_prev;

	assign q31     = prod_s2[62:31];
	assign rd_prev = (rd_idx_q == '0) ? LAW'(LINE_DEPTH - 1) : rd_idx_q - 1'b1;

	// clearing pass shares write ports with normal traffic
	always_comb begin
		line_we    = cmd.load;
		line_waddr = wp_q;
		line_wdata = clean_sample;
		coef_we    = v_s2 && upd_s2;
		coef_waddr = tap_s2;
		coef_wdata = coef_s2 + {q31[30:0], 1'b0};
		if (cmd.clear_step) begin
			line_we    = 32'(sweep_q) < LINE_DEPTH;
			line_waddr = sweep_q[LAW-1:0];
			line_wdata = '0;
			coef_we    = 32'(sweep_q) < TAPS;
			coef_waddr = sweep_q[TAW-1:0];
			coef_wdata = '0;
		end
	end

	laec_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (line_wdata),
		.raddr (rd_idx_q),
		.rdata (line_rdata)
	);

	laec_ram #(.WIDTH(32), .DEPTH(TAPS)) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (tap_q),
		.rdata (coef_rdata)
	);

	// shared multiplier operands: gain term or one tap
	always_comb begin
		if (cmd.gain_mul) begin
			mul_a = step_q;
			mul_b = err_q;
		end else begin
			mul_a = upd_s1 ? g_q : coef_rdata;
			mul_b = {line_rdata, 16'h0000};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			wp_q        <= '0;
			rd_idx_q    <= '0;
			tap_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			upd_s1      <= 1'b0;
			upd_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= STEP_RESET;
		end else begin
			if (step_size_we) begin
				step_q <= step_size;
			end
			if (cmd.clear_step) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (cmd.load) begin
				rd_idx_q <= wp_q;
				tap_q    <= '0;
				wp_q     <= (wp_q == LAW'(LINE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end else if (cmd.gain_load) begin
				rd_idx_q <= newest_q;
				tap_q    <= '0;
			end else if (cmd.issue) begin
				rd_idx_q <= rd_prev;
				tap_q    <= tap_q + 1'b1;
			end
			v_s1   <= cmd.issue;
			upd_s1 <= cmd.upd;
			v_s2   <= v_s1;
			upd_s2 <= upd_s1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tap_s1  <= tap_q;
		tap_s2  <= tap_s1;
		coef_s2 <= coef_rdata;
		prod_s2 <= 64'(mul_a) * 64'(mul_b);
		if (cmd.load) begin
			newest_q <= wp_q;
			echo_q   <= echo_sample;
			est_q    <= '0;
		end else if (v_s2 && !upd_s2) begin
			est_q <= est_q + q31;
		end
		if (cmd.err_calc) begin
			err_q <= {echo_q, 16'h0000} - est_q;
		end
		if (cmd.gain_load) begin
			g_q <= q31;
		end
		if (cmd.out_load) begin
			out_data_q <= err_q[31:16];
		end
	end

	assign status.clear_last = (sweep_q == SW'(MAXD - 1));
	assign status.last_tap   = (tap_q == TAW'(TAPS - 1));
	assign status.pipe_empty = !v_s1 && !v_s2;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign error_sample = out_data_q;

endmodule

>>> rtl/core/lms_adaptive_echo_canceller_core.sv
// ----------------------------------------------------------------------------
// lms_adaptive_echo_canceller_core
// LMS adaptive echo canceller: FIR echo estimate and per-sample weight update.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) transfers one clean reference sample and
//   one echo sample. Output channel (out_valid/out_ready) transfers the
//   cancelled error sample, the top 16 bits of the 32-bit Q31 error.
//   step_size_we writes the Q31 adaptation gain; write it only while idle.
// Timing:
//   One item at a time. After the input transfer the filter sweep issues one
//   tap per cycle through the single shared 32x32 multiplier, then the gain
//   product, then the weight update sweep on the same multiplier. out_valid
//   rises once the update sweep has drained and the output register is loaded;
//   in_ready rises together with it, so the next input can then be taken.
// Reset:
//   Delay line and weights are zeroed by a clearing pass of
//   max(LINE_DEPTH, TAPS) addresses (64 by default); in_ready stays low meanwhile.
//   The gain returns to its reset value at once.
// Stall:
//   The result sits in an output register; a new input is accepted while it
//   waits. A second result waits at the end of its update until that register
//   frees up, and no further input is taken until then.
// ----------------------------------------------------------------------------
module lms_adaptive_echo_canceller_core
	import laec_pkg::*;
#(
	parameter int TAPS       = 51,
	parameter int LINE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_size_we,
	input  logic signed [31:0] step_size,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] clean_sample,
	input  logic signed [15:0] echo_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] error_sample
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	laec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd)
	);

	// RAMs, multiplier, accumulators, output register
	laec_dp #(
		.TAPS       (TAPS),
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.step_size_we (step_size_we),
		.step_size    (step_size),
		.clean_sample (clean_sample),
		.echo_sample  (echo_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.error_sample (error_sample)
	);

	assign in_ready = cmd.in_ready;

endmodule

>>> rtl/core/laec_checker.sv
// ----------------------------------------------------------------------------
// laec_checker
// Port-level checks of the echo canceller core, bound to the top level.
// ----------------------------------------------------------------------------
module laec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] error_sample
);

	logic [1:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 2'd0)
		else $error("result transfer without a pending input");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items in flight");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken again while an item is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_sample))
		else $error("stalled result dropped or changed");

endmodule

bind lms_adaptive_echo_canceller_core laec_checker u_laec_checker (.*);

>>> test/lms_echo_checker.sv
// ----------------------------------------------------------------------------
// lms_echo_checker
// Watches both channels of the echo canceller and tracks its state alongside
// it: each input transfer runs the FIR estimate and weight update, and each
// output transfer is compared with the oldest predicted error sample.
// ----------------------------------------------------------------------------
module lms_echo_checker
	import laec_pkg::*;
#(
	parameter int TAPS       = 51,
	parameter int LINE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_size_we,
	input  logic signed [31:0] step_size,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] clean_sample,
	input  logic signed [15:0] echo_sample,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] error_sample,
	output int                 fail_count,
	output int                 awaiting,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] history [LINE_DEPTH];
	logic [31:0] weights [TAPS];
	int          write_slot;
	logic [31:0] gain;
	logic [15:0] predicted_errors [$];
	logic [15:0] oldest;

	// (a * b) >> 31 on the exact 64-bit product, kept at 32 bits
	function automatic logic [31:0] q31_product(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint wide_a;
		longint wide_b;
		longint prod;
		wide_a = longint'(a);
		wide_b = longint'(b);
		prod = (wide_a * wide_b) >>> 31;
		return prod[31:0];
	endfunction

	// One sample through the canceller; returns the top half of the error
	function automatic logic [15:0] cancel_echo(input logic [15:0] clean,
			input logic [15:0] echo);
		int          newest;
		int          slot;
		logic [31:0] estimate;
		logic [31:0] err;
		logic [31:0] scaled;
		logic [31:0] delta;
		newest = write_slot;
		history[newest] = clean;
		estimate = '0;
		slot = newest;
		for (int i = 0; i < TAPS; i++) begin
			estimate += q31_product(weights[i], {history[slot], 16'h0000});
			slot = (slot == 0) ? LINE_DEPTH - 1 : slot - 1;
		end
		write_slot = (newest + 1 >= LINE_DEPTH) ? 0 : newest + 1;
		err = {echo, 16'h0000} - estimate;
		scaled = q31_product(gain, err);
		slot = newest;
		for (int i = 0; i < TAPS; i++) begin
			delta = q31_product(scaled, {history[slot], 16'h0000});
			weights[i] = weights[i] + delta + delta;
			slot = (slot == 0) ? LINE_DEPTH - 1 : slot - 1;
		end
		return err[31:16];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (history[k]) history[k] = '0;
			foreach (weights[k]) weights[k] = '0;
			write_slot = 0;
			gain = STEP_RESET;
			predicted_errors.delete();
			fail_count = 0;
			awaiting = 0;
			checked = 0;
		end else begin
			// result side first: a result never leaves in the cycle its input arrives
			if (out_valid && out_ready) begin
				if (predicted_errors.size() == 0) begin
					$error("error_sample: expected nothing, actual %0d", error_sample);
					fail_count++;
				end else begin
					oldest = predicted_errors.pop_front();
					if (error_sample !== oldest) begin
						$error("error_sample: expected %0d, actual %0d",
							$signed(oldest), error_sample);
						fail_count++;
					end
					checked++;
				end
			end
			if (step_size_we)
				gain = step_size;
			if (in_valid && in_ready)
				predicted_errors.push_back(cancel_echo(clean_sample, echo_sample));
			awaiting = predicted_errors.size();
		end
	end

endmodule

>>> test/lms_adaptive_echo_canceller_core_tb.sv
// ----------------------------------------------------------------------------
// lms_adaptive_echo_canceller_core_tb
// Drives the echo canceller with directed corner samples and then with
// random phases of echo-path audio, noise and full-scale values under
// several adaptation gains; a checker beside the core predicts every error
// sample, and this top gives the verdict.
// ----------------------------------------------------------------------------
module lms_adaptive_echo_canceller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import laec_pkg::*;

	localparam int TAPS        = 51;
	localparam int LINE_DEPTH  = 64;
	// how long one item occupies the core when the output does not stall
	localparam int ITEM_CYCLES = 2 * TAPS + 11;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 185;
	localparam int DRAIN_LIMIT = 200000;

	logic               clk;
	logic               arst_n;
	logic               step_size_we;
	logic signed [31:0] step_size;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] clean_sample;
	logic signed [15:0] echo_sample;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] error_sample;

	int fail_count;
	int awaiting;
	int checked;
	int samples_sent;
	int gain_settings;

	lms_adaptive_echo_canceller_core #(
		.TAPS       (TAPS),
		.LINE_DEPTH (LINE_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_size_we (step_size_we),
		.step_size    (step_size),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.clean_sample (clean_sample),
		.echo_sample  (echo_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.error_sample (error_sample)
	);

	lms_echo_checker #(
		.TAPS       (TAPS),
		.LINE_DEPTH (LINE_DEPTH)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_size_we (step_size_we),
		.step_size    (step_size),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.clean_sample (clean_sample),
		.echo_sample  (echo_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.error_sample (error_sample),
		.fail_count   (fail_count),
		.awaiting     (awaiting),
		.checked      (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run (every item waiting out a
	// full sender gap, a full receiver stall and the core's own cycles).
	initial begin
		#40_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: stretches of always-ready, coin-flip, mostly-stalled and
	// fully-stalled, each of random length, so backpressure lands on every
	// phase of the core's sweep.
	initial begin
		int mode;
		int span;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = (mode == 3) ? $urandom_range(1, 250) : $urandom_range(1, 600);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= 1'b0;
				endcase
			end
		end
	end

	// Present one sample and hold it until the core takes it. Called at a
	// falling edge and returns at the falling edge after the transfer, with
	// valid still high so a burst continues without a dip.
	task automatic send_sample(input logic signed [15:0] c, input logic signed [15:0] e);
		in_valid <= 1'b1;
		clean_sample <= c;
		echo_sample <= e;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		samples_sent++;
	endtask

	// Sender gap; n is at least one so valid never drops and rises in one step
	task automatic hold_off(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Wait until every predicted error has been taken; the core is idle then
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// The caller must make gain writes only while the core is idle; this task does not enforce it
	task automatic load_step_size(input logic [31:0] value);
		step_size_we <= 1'b1;
		step_size <= value;
		@(negedge clk);
		step_size_we <= 1'b0;
		@(negedge clk);
		gain_settings++;
	endtask

	initial begin
		int                 burst;
		int                 sent;
		int                 kind;
		int                 v;
		int                 echo_delay;
		int                 echo_shift;
		bit                 loud;
		logic signed [15:0] c;
		logic signed [15:0] e;
		logic signed [15:0] recent [8];
		logic        [31:0] gain_now;

		samples_sent = 0;
		gain_settings = 0;
		arst_n = 1'b0;
		step_size_we = 1'b0;
		step_size = '0;
		in_valid = 1'b0;
		clean_sample = '0;
		echo_sample = '0;
		foreach (recent[k]) recent[k] = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. With the most negative gain and zero weights, a
		// full-scale negative echo gives error -2^31, so gain times error is
		// the most-negative-squared product that wraps; the same happens in
		// the update against the most negative clean sample.
		load_step_size(32'h8000_0000);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(16'sd32767, 16'sd32767);
		hold_off(3);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd1, -16'sd1);
		send_sample(-16'sd1, 16'sd1);
		send_sample(16'sh5555, 16'shAAAA);
		send_sample(16'shAAAA, 16'sh5555);
		drain_results();
		load_step_size(STEP_RESET);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(16'sd32767, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(16'sd0, -16'sd32768);
		send_sample(16'sd1000, 16'sd500);
		drain_results();

		// Random phases, each with its own gain, loudness and echo path.
		// Most samples follow a delayed, attenuated copy of the clean
		// signal plus a little noise, so the weights actually adapt.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: gain_now = STEP_RESET;
				1: gain_now = 32'h7FFF_FFFF;
				2: gain_now = 32'h8000_0000;
				3: gain_now = 32'h0000_0000;
				4: gain_now = 32'h0000_0001;
				5: gain_now = 32'hFFFF_FFFF;
				default: gain_now = $urandom;
			endcase
			load_step_size(gain_now);
			loud = 1'($urandom_range(0, 1));
			echo_delay = $urandom_range(0, 7);
			echo_shift = $urandom_range(1, 3);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 12);
				for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
					kind = $urandom_range(0, 9);
					if (kind < 7) begin
						if (loud) begin
							c = 16'($urandom);
						end else begin
							v = $urandom_range(0, 2047);
							c = 16'(v - 1024);
						end
						for (int j = 7; j > 0; j--) recent[j] = recent[j - 1];
						recent[0] = c;
						v = int'(recent[echo_delay]);
						v = (v >>> echo_shift) + int'($urandom_range(0, 127)) - 64;
						e = 16'(v);
					end else if (kind < 9) begin
						// plain noise on both channels
						c = 16'($urandom);
						e = 16'($urandom);
					end else begin
						case ($urandom_range(0, 2))
							0: c = -16'sd32768;
							1: c = 16'sd32767;
							default: c = 16'sd0;
						endcase
						case ($urandom_range(0, 2))
							0: e = -16'sd32768;
							1: e = 16'sd32767;
							default: e = 16'sd0;
						endcase
					end
					send_sample(c, e);
					sent++;
				end
				// a quarter of bursts run straight into the next one
				if ($urandom_range(0, 3) != 0)
					hold_off($urandom_range(1, 160));
			end
			drain_results();
		end

		// Final drain, bounded; anything still expected counts as a failure
		in_valid <= 1'b0;
		for (int n = 0; awaiting != 0 && n < DRAIN_LIMIT; n++) @(negedge clk);
		repeat (ITEM_CYCLES + 10) @(negedge clk);

		$display("Covered %0d samples under %0d gain settings, %0d error samples compared.",
			samples_sent, gain_settings, checked);
		if (fail_count == 0 && awaiting == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
